// ===== design/hsv_to_rgb_converter_defines.svh =====
// ----------------------------------------------------------------------------
// hsv to rgb converter assertion macros
// shared assertion wrappers, clocked on the rising edge, off during reset
// ----------------------------------------------------------------------------
`ifndef HSV_TO_RGB_CONVERTER_DEFINES_SVH
`define HSV_TO_RGB_CONVERTER_DEFINES_SVH

// condition holds in the same cycle as the trigger
`define HSV2RGB_ASSERT_NOW(label, clk, rst_n, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

// condition holds in the cycle after the trigger
`define HSV2RGB_ASSERT_NEXT(label, clk, rst_n, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

// ===== design/hsv2rgb_pkg.sv =====
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// pixel types, fixed-point constants and the level to channel scaling
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

    typedef struct packed {
        logic [14:0] hue;
        logic [15:0] saturation;
        logic [15:0] brightness;
    } t_hsv_pixel;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb_pixel;

    localparam logic [14:0] HUE_FULL = 15'd23040;
    localparam logic [14:0] BASE_1   = 15'd3840;
    localparam logic [14:0] BASE_2   = 15'd7680;
    localparam logic [14:0] BASE_3   = 15'd11520;
    localparam logic [14:0] BASE_4   = 15'd15360;
    localparam logic [14:0] BASE_5   = 15'd19200;
    localparam logic [15:0] ONE_Q15  = 16'd32768;
    // ceil(2^23 / 15), exact quotient for dividends below 2^23 / 7
    localparam logic [19:0] RECIP_15 = 20'd559241;

    localparam logic [2:0] SECTOR_0 = 3'd0;
    localparam logic [2:0] SECTOR_1 = 3'd1;
    localparam logic [2:0] SECTOR_2 = 3'd2;
    localparam logic [2:0] SECTOR_3 = 3'd3;
    localparam logic [2:0] SECTOR_4 = 3'd4;
    localparam logic [2:0] SECTOR_5 = 3'd5;

    // floor(x * 255 / 32768) for x up to 32768
    function automatic logic [7:0] to_chan(input logic [15:0] x);
        logic [23:0] prod;
        prod = {x, 8'h00} - {8'h00, x};
        return prod[22:15];
    endfunction

endpackage

// ===== design/hsv_to_rgb_converter.sv =====
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// hexcone hsv to 8-bit rgb conversion, five-stage pipeline
// ----------------------------------------------------------------------------
// Sustains one pixel per clock while o_stall is low; each accepted pixel
// runs through the stage registers in order. Each pipeline stage is at
// most one multiply deep: hue split, sector fraction, the s*f, s*(1-f) and p
// products side by side, the q and t products side by side, then 8-bit
// scaling and sector routing. Every stage has its own valid bit and loads
// whenever it is empty or the stage after it moves, so bubbles are squeezed
// out while the output is stalled. Hue values of 23040 and above wrap once;
// saturation and brightness clamp to 1.0.
`include "hsv_to_rgb_converter_defines.svh"

module hsv_to_rgb_converter (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  hsv2rgb_pkg::t_hsv_pixel i_pixel,
    output logic                    o_valid,
    input  logic                    i_stall,
    output hsv2rgb_pkg::t_rgb_pixel o_pixel
);
    import hsv2rgb_pkg::*;

    logic en1, en2, en3, en4, en5;

    logic        r_s1_vld, r_s2_vld, r_s3_vld, r_s4_vld, r_s5_vld;
    logic [2:0]  r_s1_sector, r_s2_sector, r_s3_sector, r_s4_sector;
    logic [11:0] r_s1_rem;
    logic [15:0] r_s1_sat, r_s2_sat;
    logic [15:0] r_s1_val, r_s2_val, r_s3_val, r_s4_val;
    logic [14:0] r_s2_frac;
    logic [15:0] r_s3_sf, r_s3_snf, r_s3_p;
    logic [15:0] r_s4_p, r_s4_q, r_s4_t;
    t_rgb_pixel  r_s5_pixel;

    logic [14:0] h_wrap;
    logic [14:0] h_base;
    logic [2:0]  n_s1_sector;
    logic [14:0] h_rem;
    logic [15:0] n_s1_sat, n_s1_val;
    logic [38:0] frac_prod;
    logic [30:0] sf_prod;
    logic [31:0] snf_prod, p_prod, q_prod, t_prod;
    logic [7:0]  ch_v, ch_p, ch_q, ch_t;
    t_rgb_pixel  n_s5_pixel;

    // stage enables: a stage loads when empty or when its content moves on
    assign en5 = !r_s5_vld || !i_stall;
    assign en4 = !r_s4_vld || en5;
    assign en3 = !r_s3_vld || en4;
    assign en2 = !r_s2_vld || en3;
    assign en1 = !r_s1_vld || en2;
    assign o_stall = !en1;

    // stage 1: wrap, clamp, sector split
    always_comb begin
        h_wrap   = (i_pixel.hue >= HUE_FULL) ? (i_pixel.hue - HUE_FULL) : i_pixel.hue;
        n_s1_sat = (i_pixel.saturation > ONE_Q15) ? ONE_Q15 : i_pixel.saturation;
        n_s1_val = (i_pixel.brightness > ONE_Q15) ? ONE_Q15 : i_pixel.brightness;
        if (h_wrap >= BASE_5) begin
            n_s1_sector = SECTOR_5;
            h_base      = BASE_5;
        end else if (h_wrap >= BASE_4) begin
            n_s1_sector = SECTOR_4;
            h_base      = BASE_4;
        end else if (h_wrap >= BASE_3) begin
            n_s1_sector = SECTOR_3;
            h_base      = BASE_3;
        end else if (h_wrap >= BASE_2) begin
            n_s1_sector = SECTOR_2;
            h_base      = BASE_2;
        end else if (h_wrap >= BASE_1) begin
            n_s1_sector = SECTOR_1;
            h_base      = BASE_1;
        end else begin
            n_s1_sector = SECTOR_0;
            h_base      = 15'd0;
        end
        h_rem = h_wrap - h_base;
    end

    // stage 2: f = rem * 128 / 15 through the reciprocal
    assign frac_prod = {8'd0, r_s1_rem, 7'd0} * {19'd0, RECIP_15};

    // stage 3: s*f, s*(1-f) and p
    assign sf_prod  = {15'd0, r_s2_sat} * {16'd0, r_s2_frac};
    assign snf_prod = {16'd0, r_s2_sat} * {16'd0, ONE_Q15 - {1'b0, r_s2_frac}};
    assign p_prod   = {16'd0, r_s2_val} * {16'd0, ONE_Q15 - r_s2_sat};

    // stage 4: q and t
    assign q_prod = {16'd0, r_s3_val} * {16'd0, ONE_Q15 - r_s3_sf};
    assign t_prod = {16'd0, r_s3_val} * {16'd0, ONE_Q15 - r_s3_snf};

    // stage 5: scale to 8 bits and route by sector
    always_comb begin
        ch_v = to_chan(r_s4_val);
        ch_p = to_chan(r_s4_p);
        ch_q = to_chan(r_s4_q);
        ch_t = to_chan(r_s4_t);
        case (r_s4_sector)
            SECTOR_0: n_s5_pixel = '{red: ch_v, green: ch_t, blue: ch_p};
            SECTOR_1: n_s5_pixel = '{red: ch_q, green: ch_v, blue: ch_p};
            SECTOR_2: n_s5_pixel = '{red: ch_p, green: ch_v, blue: ch_t};
            SECTOR_3: n_s5_pixel = '{red: ch_p, green: ch_q, blue: ch_v};
            SECTOR_4: n_s5_pixel = '{red: ch_t, green: ch_p, blue: ch_v};
            default:  n_s5_pixel = '{red: ch_v, green: ch_p, blue: ch_q};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
            r_s5_vld <= 1'b0;
        end else begin
            if (en1) r_s1_vld <= i_valid;
            if (en2) r_s2_vld <= r_s1_vld;
            if (en3) r_s3_vld <= r_s2_vld;
            if (en4) r_s4_vld <= r_s3_vld;
            if (en5) r_s5_vld <= r_s4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1_sector <= n_s1_sector;
            r_s1_rem    <= h_rem[11:0];
            r_s1_sat    <= n_s1_sat;
            r_s1_val    <= n_s1_val;
        end
        if (en2) begin
            r_s2_sector <= r_s1_sector;
            r_s2_frac   <= frac_prod[37:23];
            r_s2_sat    <= r_s1_sat;
            r_s2_val    <= r_s1_val;
        end
        if (en3) begin
            r_s3_sector <= r_s2_sector;
            r_s3_sf     <= {1'b0, sf_prod[29:15]};
            r_s3_snf    <= snf_prod[30:15];
            r_s3_p      <= p_prod[30:15];
            r_s3_val    <= r_s2_val;
        end
        if (en4) begin
            r_s4_sector <= r_s3_sector;
            r_s4_p      <= r_s3_p;
            r_s4_q      <= q_prod[30:15];
            r_s4_t      <= t_prod[30:15];
            r_s4_val    <= r_s3_val;
        end
        if (en5) begin
            r_s5_pixel  <= n_s5_pixel;
        end
    end

    assign o_valid = r_s5_vld;
    assign o_pixel = r_s5_pixel;

    `HSV2RGB_ASSERT_NEXT(a_accept_fills_s1, i_clk, i_rst_n, i_valid && !o_stall, r_s1_vld, "accepted transaction did not reach stage one")
    `HSV2RGB_ASSERT_NOW(a_sector_range, i_clk, i_rst_n, r_s1_vld, r_s1_sector <= SECTOR_5 && r_s1_rem < BASE_1[11:0], "hue split out of range")
    `HSV2RGB_ASSERT_NOW(a_levels_below_v, i_clk, i_rst_n, r_s4_vld, r_s4_p <= r_s4_val && r_s4_q <= r_s4_val && r_s4_t <= r_s4_val, "level exceeds brightness")

endmodule
